// ----- src/iim_pkg.sv -----
// ----------------------------------------------------------------------------
// iim_pkg: shared types and constants for the interval insert/merge block
// Field widths, configuration register indexes, the item tag carried from
// the front to the back, and the result record.
// ----------------------------------------------------------------------------
package iim_pkg;

  // width of every coordinate field on the ports
  localparam int FIELD_W = 32;

  // default internal coordinate width
  localparam int COORD_BITS_DEF = 32;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_NEW_LO = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEW_HI = 1'd1;

  // depth of the front to back item queue
  localparam int QUEUE_DEPTH = 2;

  // depth of the result buffer in the back
  localparam int OUT_DEPTH = 4;

  // classification of one accepted item
  typedef struct packed {
    logic first;  // first item of a list
    logic fin;    // item ends the list
    logic none;   // item carries no interval
  } tag_t;

  localparam int TAG_W = $bits(tag_t);

  // one result interval as seen on the output port
  typedef struct packed {
    logic signed [FIELD_W-1:0] lo;
    logic signed [FIELD_W-1:0] hi;
    logic                      fin;
  } res_t;

endpackage

// ----- src/iim_seg_if.sv -----
// ----------------------------------------------------------------------------
// iim_seg_if: input channel of list intervals
// Valid/ready channel; a transfer takes place when both are high.
// ----------------------------------------------------------------------------
interface iim_seg_if;
  import iim_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] seg_lo;
  logic signed [FIELD_W-1:0] seg_hi;
  logic                      seg_final;
  logic                      no_segment;

  modport source (output valid, output seg_lo, output seg_hi, output seg_final,
                  output no_segment, input ready);
  modport sink (input valid, input seg_lo, input seg_hi, input seg_final,
                input no_segment, output ready);
endinterface

// ----- src/iim_res_if.sv -----
// ----------------------------------------------------------------------------
// iim_res_if: output channel of result intervals
// Valid/ready channel; a transfer takes place when both are high.
// ----------------------------------------------------------------------------
interface iim_res_if;
  import iim_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] out_lo;
  logic signed [FIELD_W-1:0] out_hi;
  logic                      out_final;

  modport source (output valid, output out_lo, output out_hi, output out_final,
                  input ready);
  modport sink (input valid, input out_lo, input out_hi, input out_final,
                output ready);
endinterface

// ----- src/iim_queue.sv -----
// ----------------------------------------------------------------------------
// iim_queue: short item queue between front and back
// Small register FIFO; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module iim_queue #(
  parameter int WIDTH = 2 * iim_pkg::COORD_BITS_DEF + iim_pkg::TAG_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  import iim_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  // handshake
  assign push_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;
  assign pop_data   = mem[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      end
      count <= count + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end
endmodule

// ----- src/iim_front.sv -----
// ----------------------------------------------------------------------------
// iim_front: configuration and item intake
// Holds the new interval registers, keeps the ordered start bounds ready,
// tags each accepted item (list start, list end, empty) and queues it.
// ----------------------------------------------------------------------------
module iim_front #(
  parameter int COORD_BITS = iim_pkg::COORD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [iim_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [iim_pkg::FIELD_W-1:0]           cfg_data,
  iim_seg_if.sink                               seg,
  output logic                                  push_valid,
  input  logic                                  push_ready,
  output logic [2*COORD_BITS+iim_pkg::TAG_W-1:0] push_data,
  output logic [COORD_BITS-1:0]                 init_lo,
  output logic [COORD_BITS-1:0]                 init_hi
);
  import iim_pkg::*;

  localparam int WIDE = (COORD_BITS > FIELD_W) ? COORD_BITS : FIELD_W;

  logic [FIELD_W-1:0]    new_lo;
  logic [FIELD_W-1:0]    new_hi;
  logic [COORD_BITS-1:0] cfg_a;
  logic [COORD_BITS-1:0] cfg_b;
  logic                  in_list;
  logic                  accept;
  tag_t                  tag;

  // field to coordinate: zero extend, then keep the low coordinate bits
  function automatic logic [COORD_BITS-1:0] to_coord(input logic [FIELD_W-1:0] f);
    logic [WIDE-1:0] t;
    t = WIDE'(f);
    return t[COORD_BITS-1:0];
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      new_lo <= '0;
      new_hi <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NEW_LO: new_lo <= cfg_data;
        REG_NEW_HI: new_hi <= cfg_data;
        default: ;
      endcase
    end
  end

  // start bounds of a list, swapped when given reversed
  assign cfg_a = to_coord(new_lo);
  assign cfg_b = to_coord(new_hi);

  always_ff @(posedge clk) begin
    if ($signed(cfg_b) < $signed(cfg_a)) begin
      init_lo <= cfg_b;
      init_hi <= cfg_a;
    end else begin
      init_lo <= cfg_a;
      init_hi <= cfg_b;
    end
  end

  // item tagging; an empty item always ends the list
  assign tag.first  = ~in_list;
  assign tag.none   = seg.no_segment;
  assign tag.fin    = seg.seg_final | seg.no_segment;

  assign push_valid = seg.valid;
  assign seg.ready  = push_ready;
  assign accept     = seg.valid & push_ready;
  assign push_data  = {to_coord(seg.seg_lo), to_coord(seg.seg_hi), tag};

  // list tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      in_list <= 1'b0;
    end else if (accept) begin
      in_list <= ~tag.fin;
    end
  end
endmodule

// ----- src/iim_back.sv -----
// ----------------------------------------------------------------------------
// iim_back: merge engine and result buffer
// Takes one tagged item a cycle while two result slots are free, compares
// it against the pending merged interval, updates the bounds and writes up to
// two results into a small buffer that drives the output channel.
// ----------------------------------------------------------------------------
module iim_back #(
  parameter int COORD_BITS = iim_pkg::COORD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  pop_valid,
  output logic                                  pop_ready,
  input  logic [2*COORD_BITS+iim_pkg::TAG_W-1:0] pop_data,
  input  logic [COORD_BITS-1:0]                 init_lo,
  input  logic [COORD_BITS-1:0]                 init_hi,
  iim_res_if.source                             res
);
  import iim_pkg::*;

  localparam int WIDE  = (COORD_BITS > FIELD_W) ? COORD_BITS : FIELD_W;
  localparam int ITEM_W = 2 * COORD_BITS + TAG_W;
  localparam int OPTR_W = $clog2(OUT_DEPTH);
  localparam int OCNT_W = $clog2(OUT_DEPTH + 1);

  logic [COORD_BITS-1:0] h_lo;
  logic [COORD_BITS-1:0] h_hi;
  tag_t                  h_tag;

  logic [COORD_BITS-1:0] merge_lo;
  logic [COORD_BITS-1:0] merge_hi;
  logic                  placed;
  logic [COORD_BITS-1:0] merge_lo_next;
  logic [COORD_BITS-1:0] merge_hi_next;
  logic                  placed_next;

  logic [COORD_BITS-1:0] cur_lo;
  logic [COORD_BITS-1:0] cur_hi;
  logic                  cur_placed;
  logic                  ends_before;
  logic                  starts_after;

  res_t                  e0;
  res_t                  e1;
  logic                  e0_v;
  logic                  e1_v;
  logic                  fire;

  res_t                  obuf [OUT_DEPTH];
  logic [OPTR_W-1:0]     wptr;
  logic [OPTR_W-1:0]     rptr;
  logic [OCNT_W-1:0]     count;
  logic                  res_xfer;

  // coordinate to field: sign extend, then keep the low field bits
  function automatic logic [FIELD_W-1:0] to_field(input logic [COORD_BITS-1:0] x);
    logic signed [WIDE-1:0] t;
    t = WIDE'($signed(x));
    return t[FIELD_W-1:0];
  endfunction

  // unpack the queued item
  assign h_lo  = pop_data[ITEM_W-1 -: COORD_BITS];
  assign h_hi  = pop_data[ITEM_W-COORD_BITS-1 -: COORD_BITS];
  assign h_tag = tag_t'(pop_data[TAG_W-1:0]);

  // a list start reloads the bounds from the new interval
  assign cur_lo     = h_tag.first ? init_lo : merge_lo;
  assign cur_hi     = h_tag.first ? init_hi : merge_hi;
  assign cur_placed = ~h_tag.first & placed;

  assign ends_before  = $signed(h_hi) < $signed(cur_lo);
  assign starts_after = $signed(cur_hi) < $signed(h_lo);

  // classify against the merged interval and build the results
  always_comb begin
    merge_lo_next = cur_lo;
    merge_hi_next = cur_hi;
    placed_next   = cur_placed;
    e0_v          = 1'b0;
    e1_v          = 1'b0;
    e0            = '{lo: to_field(h_lo), hi: to_field(h_hi), fin: h_tag.fin};
    e1            = '{lo: to_field(cur_lo), hi: to_field(cur_hi), fin: 1'b1};

    if (h_tag.none) begin
      // empty item: release the merged interval if still pending
      e0_v = ~cur_placed;
      e0   = '{lo: to_field(cur_lo), hi: to_field(cur_hi), fin: 1'b1};
    end else if (cur_placed) begin
      // already placed: pass through
      e0_v = 1'b1;
    end else if (ends_before) begin
      // interval lies before: pass it, release merged at list end
      e0_v   = 1'b1;
      e0.fin = 1'b0;
      e1_v   = h_tag.fin;
    end else if (starts_after) begin
      // interval lies after: merged first, then the interval
      e0_v        = 1'b1;
      e0          = '{lo: to_field(cur_lo), hi: to_field(cur_hi), fin: 1'b0};
      e1_v        = 1'b1;
      e1          = '{lo: to_field(h_lo), hi: to_field(h_hi), fin: h_tag.fin};
      placed_next = 1'b1;
    end else begin
      // overlap or touch: widen the bounds
      if ($signed(h_lo) < $signed(cur_lo)) begin
        merge_lo_next = h_lo;
      end
      if ($signed(cur_hi) < $signed(h_hi)) begin
        merge_hi_next = h_hi;
      end
      e0_v = h_tag.fin;
      e0   = '{lo: to_field(merge_lo_next), hi: to_field(merge_hi_next), fin: 1'b1};
    end

    if (h_tag.fin) begin
      placed_next = 1'b0;
    end
  end

  // take an item only when two result slots are free
  assign pop_ready = (count <= OCNT_W'(OUT_DEPTH - 2));
  assign fire      = pop_valid & pop_ready;

  // merge state
  always_ff @(posedge clk) begin
    if (fire) begin
      merge_lo <= merge_lo_next;
      merge_hi <= merge_hi_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      placed <= 1'b0;
    end else if (fire) begin
      placed <= placed_next;
    end
  end

  // result buffer storage
  always_ff @(posedge clk) begin
    if (fire && e0_v) begin
      obuf[wptr] <= e0;
    end
    if (fire && e1_v) begin
      obuf[wptr + OPTR_W'(1)] <= e1;
    end
  end

  // result buffer pointers and fill count
  assign res_xfer = res.valid & res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (fire) begin
        wptr <= wptr + OPTR_W'(e0_v) + OPTR_W'(e1_v);
      end
      if (res_xfer) begin
        rptr <= rptr + OPTR_W'(1);
      end
      count <= count + (fire ? (OCNT_W'(e0_v) + OCNT_W'(e1_v)) : '0)
               - OCNT_W'(res_xfer);
    end
  end

  // output channel
  assign res.valid     = (count != '0);
  assign res.out_lo    = obuf[rptr].lo;
  assign res.out_hi    = obuf[rptr].hi;
  assign res.out_final = obuf[rptr].fin;
endmodule

// ----- src/interval_insert_merge.sv -----
// ----------------------------------------------------------------------------
// interval_insert_merge: insert one interval into a sorted interval stream
// Merges the configured interval with every overlapping or touching list
// interval and streams out the resulting sorted list.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_we/cfg_index/cfg_data write new_lo (index 0) and new_hi (index 1)
//   between lists; a reversed pair is swapped at the start of a list.
//   seg carries one list interval per transfer, seg_final on the last one;
//   an item with no_segment set ends an empty list (or any list).
//   res carries the result intervals, out_final on the last of each list.
// Timing:
//   an item passes through the registered item queue and then the result
//   buffer before its first result is valid on res.
//   One item is taken every cycle while two result slots are free; an item
//   yielding two results holds the sustained rate to one result a cycle, set
//   by the single output channel draining the four-entry result buffer.
// Reset: clears the new interval to 0, list tracking and all queues.
// Stalls: when res is not ready the result buffer fills, the back stops
//   taking items, the two-entry item queue fills and seg.ready drops.
// ----------------------------------------------------------------------------
module interval_insert_merge #(
  parameter int COORD_BITS = iim_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [iim_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [iim_pkg::FIELD_W-1:0]   cfg_data,
  iim_seg_if.sink                       seg,
  iim_res_if.source                     res
);
  import iim_pkg::*;

  localparam int ITEM_W = 2 * COORD_BITS + TAG_W;

  logic                  push_valid;
  logic                  push_ready;
  logic [ITEM_W-1:0]     push_data;
  logic                  pop_valid;
  logic                  pop_ready;
  logic [ITEM_W-1:0]     pop_data;
  logic [COORD_BITS-1:0] init_lo;
  logic [COORD_BITS-1:0] init_hi;

  // intake and configuration
  iim_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .seg        (seg),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .init_lo    (init_lo),
    .init_hi    (init_hi)
  );

  // item queue
  iim_queue #(.WIDTH(ITEM_W)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // merge engine and results
  iim_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .init_lo   (init_lo),
    .init_hi   (init_hi),
    .res       (res)
  );
endmodule

// ----- tb/interval_insert_merge_tb.sv -----
// ----------------------------------------------------------------------------
// interval_insert_merge_tb: self-checking bench for the interval insert block
// Streams directed and random interval lists through the seg channel and
// checks every result interval against an in-bench model of the merge.
// Both channels idle at random, and the inserted interval is changed between
// phases, sometimes while a list is still open.
// ----------------------------------------------------------------------------
module interval_insert_merge_tb;
  import iim_pkg::*;

  localparam int RANDOM_SEGS   = 1750;
  localparam int SETTLE_CYCLES = 8;
  localparam logic signed [FIELD_W-1:0] COORD_MIN = {1'b1, {(FIELD_W-1){1'b0}}};
  localparam logic signed [FIELD_W-1:0] COORD_MAX = {1'b0, {(FIELD_W-1){1'b1}}};

  // one list interval as driven on the seg channel
  typedef struct packed {
    logic signed [FIELD_W-1:0] lo;
    logic signed [FIELD_W-1:0] hi;
    logic                      fin;
    logic                      none;
  } seg_item_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [FIELD_W-1:0]   cfg_data;

  iim_seg_if seg();
  iim_res_if res();

  interval_insert_merge u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .seg       (seg),
    .res       (res)
  );

  always #1 clk = ~clk;

  // stimulus and expected result intervals
  seg_item_t seg_pending[$];
  seg_item_t list_buf[$];
  seg_item_t carry_buf[$];
  res_t      merged_ivals[$];
  int        segs_sent  = 0;
  int        segs_taken = 0;
  int        errors     = 0;
  int        seg_gap_max;
  int        res_stall_max;
  int        seg_wait;
  int        res_wait;
  int        list_scale = 20;
  seg_item_t seg_cur;
  res_t      want;

  // model copy of the registers and the merge state
  logic signed [FIELD_W-1:0] cfg_new_lo = '0;
  logic signed [FIELD_W-1:0] cfg_new_hi = '0;
  logic signed [FIELD_W-1:0] mrg_lo     = '0;
  logic signed [FIELD_W-1:0] mrg_hi     = '0;
  logic                      placed     = 1'b0;
  logic                      in_list    = 1'b0;

  function automatic void emit(logic signed [FIELD_W-1:0] lo,
                               logic signed [FIELD_W-1:0] hi, logic fin);
    res_t r;
    r.lo  = lo;
    r.hi  = hi;
    r.fin = fin;
    merged_ivals.insert(merged_ivals.size(), r);
  endfunction

  // merge one accepted list interval, queueing the intervals it releases
  function automatic void merge_interval(seg_item_t it);
    logic ends_list;
    ends_list = it.fin;
    // new list: load the inserted interval, swapped if reversed
    if (!in_list) begin
      if (cfg_new_hi < cfg_new_lo) begin
        mrg_lo = cfg_new_hi;
        mrg_hi = cfg_new_lo;
      end else begin
        mrg_lo = cfg_new_lo;
        mrg_hi = cfg_new_hi;
      end
      placed  = 1'b0;
      in_list = 1'b1;
    end
    if (it.none) begin
      if (!placed) emit(mrg_lo, mrg_hi, 1'b1);
      ends_list = 1'b1;
    end else if (placed) begin
      emit(it.lo, it.hi, it.fin);
    end else if (it.hi < mrg_lo) begin
      emit(it.lo, it.hi, 1'b0);
      if (it.fin) emit(mrg_lo, mrg_hi, 1'b1);
    end else if (mrg_hi < it.lo) begin
      emit(mrg_lo, mrg_hi, 1'b0);
      emit(it.lo, it.hi, it.fin);
      placed = 1'b1;
    end else begin
      // overlap or shared end point widens the merged bounds
      if (it.lo < mrg_lo) mrg_lo = it.lo;
      if (mrg_hi < it.hi) mrg_hi = it.hi;
      if (it.fin) emit(mrg_lo, mrg_hi, 1'b1);
    end
    if (ends_list) begin
      in_list = 1'b0;
      placed  = 1'b0;
    end
  endfunction

  // seg driver: random gap before each item, model runs on each transfer
  always @(posedge clk) begin
    if (rst) begin
      seg.valid <= 1'b0;
      seg_wait = 0;
    end else begin
      if (seg.valid && seg.ready) begin
        merge_interval(seg_cur);
        segs_taken++;
      end
      if (!seg.valid || seg.ready) begin
        if (seg_wait > 0) begin
          seg_wait--;
          seg.valid <= 1'b0;
        end else if (seg_pending.size() != 0) begin
          seg_cur = seg_pending.pop_front();
          seg.seg_lo     <= seg_cur.lo;
          seg.seg_hi     <= seg_cur.hi;
          seg.seg_final  <= seg_cur.fin;
          seg.no_segment <= seg_cur.none;
          seg.valid      <= 1'b1;
          seg_wait = $urandom_range(0, seg_gap_max);
        end else begin
          seg.valid <= 1'b0;
        end
      end
    end
  end

  // res monitor: compare each transfer, then stall a random number of cycles
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
      res_wait = 0;
    end else begin
      if (res.valid && res.ready) begin
        if (merged_ivals.size() == 0) begin
          $error("unexpected result interval: out_lo %0d, out_hi %0d, out_final %0b",
                 res.out_lo, res.out_hi, res.out_final);
          errors++;
        end else begin
          want = merged_ivals.pop_front();
          if (res.out_lo !== want.lo) begin
            $error("out_lo: expected %0d, actual %0d", want.lo, res.out_lo);
            errors++;
          end
          if (res.out_hi !== want.hi) begin
            $error("out_hi: expected %0d, actual %0d", want.hi, res.out_hi);
            errors++;
          end
          if (res.out_final !== want.fin) begin
            $error("out_final: expected %0b, actual %0b", want.fin, res.out_final);
            errors++;
          end
        end
        res_wait = $urandom_range(0, res_stall_max);
      end
      if (res_wait > 0) begin
        res_wait--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  function automatic void send_item(seg_item_t it);
    seg_pending.insert(seg_pending.size(), it);
    segs_sent++;
  endfunction

  function automatic void send_seg(logic signed [FIELD_W-1:0] lo,
                                   logic signed [FIELD_W-1:0] hi, logic fin, logic none);
    seg_item_t it;
    it.lo   = lo;
    it.hi   = hi;
    it.fin  = fin;
    it.none = none;
    send_item(it);
  endfunction

  // wait until every item is taken and every result is back, then a bit more
  task automatic settle();
    while (segs_taken != segs_sent || merged_ivals.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [FIELD_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == REG_NEW_LO) cfg_new_lo = val;
    else cfg_new_hi = val;
    @(posedge clk);
  endtask

  task automatic set_new_interval(logic signed [FIELD_W-1:0] lo,
                                  logic signed [FIELD_W-1:0] hi);
    write_reg(REG_NEW_LO, lo);
    write_reg(REG_NEW_HI, hi);
    cfg_we <= 1'b0;
  endtask

  // well-formed sorted list spread around the inserted interval
  function automatic void build_list();
    longint    pos, lo, hi, nlo, nhi, cmin, cmax;
    int        n, s;
    seg_item_t it;
    list_buf.delete();
    cmin = COORD_MIN;
    cmax = COORD_MAX;
    nlo  = (cfg_new_lo < cfg_new_hi) ? cfg_new_lo : cfg_new_hi;
    nhi  = (cfg_new_lo < cfg_new_hi) ? cfg_new_hi : cfg_new_lo;
    s    = list_scale;
    n    = $urandom_range(0, 8);
    pos  = nlo - longint'($urandom_range(0, n * s));
    for (int i = 0; i < n; i++) begin
      lo = pos;
      // sometimes start exactly on the end of the inserted interval
      if (lo <= nhi && nhi - lo <= s && $urandom_range(0, 3) == 0) lo = nhi;
      hi = lo + longint'($urandom_range(0, s));
      // sometimes end exactly on its start
      if (lo <= nlo && nlo - lo <= s && $urandom_range(0, 3) == 0) hi = nlo;
      if (lo > cmax) break;
      if (hi > cmax) hi = cmax;
      if (hi < cmin) begin
        pos = hi + 1 + longint'($urandom_range(0, s));
        continue;
      end
      if (lo < cmin) lo = cmin;
      it.lo   = lo[FIELD_W-1:0];
      it.hi   = hi[FIELD_W-1:0];
      it.fin  = 1'b0;
      it.none = 1'b0;
      list_buf.insert(list_buf.size(), it);
      if (hi == cmax) break;
      pos = hi + 1 + longint'($urandom_range(0, s));
    end
    // close with a no-segment item now and then, else mark the last one
    if (list_buf.size() == 0 || $urandom_range(0, 9) == 0) begin
      it.lo   = $urandom;
      it.hi   = $urandom;
      it.fin  = $urandom_range(0, 1);
      it.none = 1'b1;
      list_buf.insert(list_buf.size(), it);
    end else begin
      list_buf[list_buf.size()-1].fin = 1'b1;
    end
  endfunction

  // unordered list with arbitrary bounds, early ends and stray terminators
  function automatic void build_noise_list();
    int        n;
    seg_item_t it;
    list_buf.delete();
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      it.lo   = $urandom;
      it.hi   = $urandom;
      it.fin  = (i == n - 1) || ($urandom_range(0, 5) == 0);
      it.none = ($urandom_range(0, 9) == 0);
      list_buf.insert(list_buf.size(), it);
    end
  endfunction

  initial begin
    int                        n_lists;
    int                        cut;
    int                        rand_segs;
    int                        base;
    logic signed [FIELD_W-1:0] lo_v;
    logic signed [FIELD_W-1:0] hi_v;

    seg.valid      = 1'b0;
    seg.seg_lo     = '0;
    seg.seg_hi     = '0;
    seg.seg_final  = 1'b0;
    seg.no_segment = 1'b0;
    res.ready      = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = REG_NEW_LO;
    cfg_data       = '0;
    seg_gap_max    = 3;
    res_stall_max  = 3;
    rand_segs      = 0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // before, touching start, inside, touching end, after, final after placement
    set_new_interval(10, 20);
    send_seg(0, 5, 1'b0, 1'b0);
    send_seg(8, 10, 1'b0, 1'b0);
    send_seg(12, 14, 1'b0, 1'b0);
    send_seg(20, 25, 1'b0, 1'b0);
    send_seg(30, 40, 1'b0, 1'b0);
    send_seg(50, 60, 1'b1, 1'b0);
    // empty list, seg_final ignored
    send_seg(0, 0, 1'b0, 1'b1);
    // one-interval lists: before, merging, after
    send_seg(0, 5, 1'b1, 1'b0);
    send_seg(15, 30, 1'b1, 1'b0);
    send_seg(25, 30, 1'b1, 1'b0);
    // no-segment terminator after placement yields nothing
    send_seg(25, 30, 1'b0, 1'b0);
    send_seg(7, 7, 1'b1, 1'b1);
    // no-segment terminator releases the pending interval
    send_seg(0, 1, 1'b0, 1'b0);
    send_seg(COORD_MAX, COORD_MIN, 1'b0, 1'b1);
    // reversed list interval takes the ends-before path
    send_seg(30, 9, 1'b1, 1'b0);
    // register change in the middle of a list applies to the next list
    send_seg(0, 5, 1'b0, 1'b0);
    settle();
    set_new_interval(100, 200);
    send_seg(12, 14, 1'b1, 1'b0);
    send_seg(150, 150, 1'b1, 1'b0);
    // reversed inserted interval spanning the whole range
    settle();
    set_new_interval(COORD_MAX, COORD_MIN);
    send_seg(COORD_MIN, COORD_MIN, 1'b0, 1'b0);
    send_seg(COORD_MAX, COORD_MAX, 1'b1, 1'b0);
    // inserted interval pinned to each end of the range
    settle();
    set_new_interval(COORD_MIN, COORD_MIN);
    send_seg(COORD_MIN, COORD_MIN, 1'b0, 1'b0);
    send_seg(COORD_MIN + 1, COORD_MAX, 1'b1, 1'b0);
    settle();
    set_new_interval(COORD_MAX, COORD_MAX);
    send_seg(COORD_MIN, COORD_MAX - 1, 1'b1, 1'b0);

    // random phases, each with its own inserted interval, scale and idling
    while (rand_segs < RANDOM_SEGS) begin
      settle();
      base = int'($urandom_range(0, 4000)) - 2000;
      case ($urandom_range(0, 7))
        0: begin
          lo_v = $urandom;
          hi_v = $urandom;
        end
        1: begin
          lo_v = COORD_MIN;
          hi_v = $urandom;
        end
        2: begin
          lo_v = $urandom;
          hi_v = COORD_MAX;
        end
        3: begin
          lo_v = COORD_MIN;
          hi_v = COORD_MAX;
        end
        4: begin
          lo_v = base;
          hi_v = base;
        end
        5: begin
          lo_v = base + int'($urandom_range(0, 60));
          hi_v = base;
        end
        default: begin
          lo_v = base;
          hi_v = base + int'($urandom_range(0, 60));
        end
      endcase
      set_new_interval(lo_v, hi_v);
      case ($urandom_range(0, 3))
        0: list_scale = 3;
        1: list_scale = 20;
        2: list_scale = 5000;
        default: list_scale = 1 << 24;
      endcase
      case ($urandom_range(0, 3))
        0: seg_gap_max = 0;
        1: seg_gap_max = 8;
        default: seg_gap_max = 2;
      endcase
      case ($urandom_range(0, 3))
        0: res_stall_max = 0;
        1: res_stall_max = 8;
        default: res_stall_max = 2;
      endcase
      // rest of a list left open across the register change
      while (carry_buf.size() != 0) begin
        send_item(carry_buf.pop_front());
        rand_segs++;
      end
      n_lists = $urandom_range(2, 12);
      for (int l = 0; l < n_lists; l++) begin
        if ($urandom_range(0, 7) == 0) build_noise_list();
        else build_list();
        if (l == n_lists - 1 && list_buf.size() > 1 && $urandom_range(0, 1) == 1)
          cut = $urandom_range(1, list_buf.size() - 1);
        else
          cut = list_buf.size();
        foreach (list_buf[i]) begin
          if (i < cut) send_item(list_buf[i]);
          else carry_buf.insert(carry_buf.size(), list_buf[i]);
        end
        rand_segs += cut;
      end
    end
    while (carry_buf.size() != 0) send_item(carry_buf.pop_front());
    settle();

    if (errors == 0 && merged_ivals.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
